// File: design/cpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the channel power combiner
// Item formats, queue entry, log unit handshake and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ACC_BITS    = 29;
    localparam int POWER_BITS  = 56;
    localparam int DB_BITS     = 16;

    // square of a signed sample or channel sum; the most negative value squared
    // needs one bit less than the full product
    localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
    localparam int CSQ_BITS = 2 * ACC_BITS - 1;

    // log2 in Q6.16, mantissa in Q1.31
    localparam int EXP_BITS   = 6;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_BITS   = $clog2(FRAC_BITS);
    localparam int LOG_BITS   = EXP_BITS + FRAC_BITS;
    localparam int MANT_BITS  = 32;
    localparam int BYTE_BITS  = 8;
    localparam int NUM_BYTES  = POWER_BITS / BYTE_BITS;
    localparam int BCNT_BITS  = $clog2(NUM_BYTES + 1);
    localparam int BPOS_BITS  = $clog2(BYTE_BITS);

    // 2560*log10(2) in Q.16, rounded
    localparam int SCALE_BITS = 26;
    localparam logic [SCALE_BITS-1:0] DB_SCALE = 26'd50504453;
    localparam int PROD_BITS  = LOG_BITS + SCALE_BITS;
    localparam int RND_SHIFT  = 32;

    localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMBINE_MODE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DB_ENABLE    = 1'b1;

    localparam logic MODE_COHERENT   = 1'b0;
    localparam logic MODE_INCOHERENT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] real_part;
        logic signed [SAMPLE_BITS-1:0] imag_part;
        logic                          last_channel;
    } t_in_item;

    typedef struct packed {
        logic [POWER_BITS-1:0] power;
        logic [DB_BITS-1:0]    power_db;
        logic                  zero_power;
        logic                  saturated;
    } t_out_item;

    typedef struct packed {
        logic                       mode;
        logic                       clip;
        logic signed [ACC_BITS-1:0] re_acc;
        logic signed [ACC_BITS-1:0] im_acc;
        logic [POWER_BITS-1:0]      pwr_sum;
    } t_q_entry;

    typedef struct packed {
        logic [POWER_BITS-1:0] power;
        logic                  sat;
    } t_log_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_log_stat;

    typedef enum logic [2:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_LEAD,
        LOG_ITER,
        LOG_SCALE,
        LOG_DONE
    } t_log_state;

endpackage
`default_nettype wire

// File: design/channel_power_combiner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_power_combiner: multi-channel complex power combiner
// Sums channel samples of one range sample coherently or incoherently and
// gives the power, optionally in dB.
// ----------------------------------------------------------------------------
// Input channel: one complex channel sample per item, last_channel closes a
// range sample. One result item leaves per range sample, for its last item.
// Configuration: combine_mode (index 0) and db_enable (index 1); the user must
// write them only while no range sample is in flight; the block does not check.
// Throughput: one input item per cycle while intake does not stall. Without
// dB, results leave one per cycle while the receiver does not stall; a result
// is valid once its last channel has passed stage A, the queue, B1, B2 and
// the output register. With db_enable a nonzero power also passes the dB unit
// (byte normalize, bit normalize, 16 squaring steps on one 32x32 multiplier,
// scale), which stays busy until its result leaves. A four-entry queue
// absorbs bursts; intake stalls only when a last channel finds it full.
// Reset clears the accumulators, the queue, the pipeline and both registers.
// While the receiver stalls, the result holds in the output register and
// evaluation and intake back up behind it.
// ----------------------------------------------------------------------------
module channel_power_combiner (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire cpc_pkg::t_in_item                   i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output cpc_pkg::t_out_item                       o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [cpc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [cpc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic                 r_combine_mode;
    logic                 r_db_enable;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_empty;
    cpc_pkg::t_q_entry    w_entry;
    cpc_pkg::t_q_entry    w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combine_mode <= cpc_pkg::MODE_COHERENT;
            r_db_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpc_pkg::CFG_COMBINE_MODE: r_combine_mode <= i_cfg_data[0];
                cpc_pkg::CFG_DB_ENABLE:    r_db_enable    <= i_cfg_data[0];
                default:                   r_db_enable    <= r_db_enable;
            endcase
        end
    end

    cpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_mode     (r_combine_mode),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    cpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    cpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_db_enable (r_db_enable),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: design/cpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_front: sample intake and channel accumulation
// Squares each sample, keeps the saturating channel sums and the power sum,
// and pushes the finished sums of a range sample into the queue.
// ----------------------------------------------------------------------------
module cpc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire cpc_pkg::t_in_item  i_in_item,
    input  wire logic               i_mode,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output cpc_pkg::t_q_entry       o_entry
);

    localparam int PW = 2 * cpc_pkg::SAMPLE_BITS;

    // stage A: registered sample and its squares
    logic                                  r_a_valid;
    logic                                  r_a_last;
    logic signed [cpc_pkg::SAMPLE_BITS-1:0] r_a_re;
    logic signed [cpc_pkg::SAMPLE_BITS-1:0] r_a_im;
    logic [cpc_pkg::SQ_BITS-1:0]           r_a_sq_re;
    logic [cpc_pkg::SQ_BITS-1:0]           r_a_sq_im;

    // accumulators
    logic signed [cpc_pkg::ACC_BITS-1:0]   r_acc_re;
    logic signed [cpc_pkg::ACC_BITS-1:0]   r_acc_im;
    logic [cpc_pkg::POWER_BITS-1:0]        r_acc_pwr;
    logic                                  r_clip;

    logic signed [PW-1:0]                  w_re_ext;
    logic signed [PW-1:0]                  w_im_ext;
    logic signed [PW-1:0]                  w_prod_re;
    logic signed [PW-1:0]                  w_prod_im;
    logic                                  w_take;
    logic                                  w_adv;

    logic signed [cpc_pkg::ACC_BITS:0]     w_re_sum;
    logic signed [cpc_pkg::ACC_BITS:0]     w_im_sum;
    logic [cpc_pkg::POWER_BITS:0]          w_pwr_sum;
    logic                                  w_clip_re;
    logic                                  w_clip_im;
    logic                                  w_clip_p;
    logic signed [cpc_pkg::ACC_BITS-1:0]   n_acc_re;
    logic signed [cpc_pkg::ACC_BITS-1:0]   n_acc_im;
    logic [cpc_pkg::POWER_BITS-1:0]        n_acc_pwr;
    logic                                  n_clip;

    assign w_re_ext  = PW'(i_in_item.real_part);
    assign w_im_ext  = PW'(i_in_item.imag_part);
    assign w_prod_re = w_re_ext * w_re_ext;
    assign w_prod_im = w_im_ext * w_im_ext;

    // a last-channel item waits for queue space, others never wait
    assign w_adv      = r_a_valid && (!r_a_last || !i_q_full);
    assign o_in_stall = r_a_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_take) begin
            r_a_valid <= 1'b1;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_last  <= i_in_item.last_channel;
            r_a_re    <= i_in_item.real_part;
            r_a_im    <= i_in_item.imag_part;
            r_a_sq_re <= w_prod_re[cpc_pkg::SQ_BITS-1:0];
            r_a_sq_im <= w_prod_im[cpc_pkg::SQ_BITS-1:0];
        end
    end

    assign w_re_sum  = (cpc_pkg::ACC_BITS+1)'(r_acc_re) + (cpc_pkg::ACC_BITS+1)'(r_a_re);
    assign w_im_sum  = (cpc_pkg::ACC_BITS+1)'(r_acc_im) + (cpc_pkg::ACC_BITS+1)'(r_a_im);
    assign w_pwr_sum = (cpc_pkg::POWER_BITS+1)'(r_acc_pwr)
                     + (cpc_pkg::POWER_BITS+1)'(r_a_sq_re)
                     + (cpc_pkg::POWER_BITS+1)'(r_a_sq_im);

    assign w_clip_re = w_re_sum[cpc_pkg::ACC_BITS] != w_re_sum[cpc_pkg::ACC_BITS-1];
    assign w_clip_im = w_im_sum[cpc_pkg::ACC_BITS] != w_im_sum[cpc_pkg::ACC_BITS-1];
    assign w_clip_p  = w_pwr_sum[cpc_pkg::POWER_BITS];

    always_comb begin
        if (w_clip_re) begin
            n_acc_re = w_re_sum[cpc_pkg::ACC_BITS] ? cpc_pkg::ACC_LO : cpc_pkg::ACC_HI;
        end else begin
            n_acc_re = w_re_sum[cpc_pkg::ACC_BITS-1:0];
        end
        if (w_clip_im) begin
            n_acc_im = w_im_sum[cpc_pkg::ACC_BITS] ? cpc_pkg::ACC_LO : cpc_pkg::ACC_HI;
        end else begin
            n_acc_im = w_im_sum[cpc_pkg::ACC_BITS-1:0];
        end
        n_acc_pwr = w_clip_p ? '1 : w_pwr_sum[cpc_pkg::POWER_BITS-1:0];
        // only the sums that feed the current mode mark the range sample
        n_clip = r_clip | ((i_mode == cpc_pkg::MODE_INCOHERENT) ? w_clip_p
                                                               : (w_clip_re | w_clip_im));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re  <= '0;
            r_acc_im  <= '0;
            r_acc_pwr <= '0;
            r_clip    <= 1'b0;
        end else if (w_adv) begin
            if (r_a_last) begin
                r_acc_re  <= '0;
                r_acc_im  <= '0;
                r_acc_pwr <= '0;
                r_clip    <= 1'b0;
            end else begin
                r_acc_re  <= n_acc_re;
                r_acc_im  <= n_acc_im;
                r_acc_pwr <= n_acc_pwr;
                r_clip    <= n_clip;
            end
        end
    end

    assign o_push          = w_adv && r_a_last;
    assign o_entry.mode    = i_mode;
    assign o_entry.clip    = n_clip;
    assign o_entry.re_acc  = n_acc_re;
    assign o_entry.im_acc  = n_acc_im;
    assign o_entry.pwr_sum = n_acc_pwr;

endmodule
`default_nettype wire

// File: design/cpc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_fifo: queue of finished channel sums
// Small first-in first-out buffer that lets the front and back stall apart.
// ----------------------------------------------------------------------------
module cpc_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cpc_pkg::t_q_entry i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output cpc_pkg::t_q_entry      o_head
);

    cpc_pkg::t_q_entry             r_mem [cpc_pkg::Q_DEPTH];
    logic [cpc_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [cpc_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [cpc_pkg::Q_CW-1:0]      r_count;

    assign o_full  = r_count == cpc_pkg::Q_CW'(cpc_pkg::Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cpc_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cpc_pkg::Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + cpc_pkg::Q_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - cpc_pkg::Q_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("cpc_fifo: push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("cpc_fifo: pop from empty queue");

endmodule
`default_nettype wire

// File: design/cpc_log.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_log: power to dB conversion unit
// Normalizes the power, finds 16 fraction bits of log2 by repeated squaring
// on one shared multiplier, and scales log2 to 1/256 dB.
// ----------------------------------------------------------------------------
module cpc_log (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire cpc_pkg::t_log_req i_req,
    input  wire logic              i_take,
    output cpc_pkg::t_log_stat     o_stat,
    output cpc_pkg::t_out_item     o_result
);

    cpc_pkg::t_log_state               r_state;
    cpc_pkg::t_log_state               n_state;

    logic [cpc_pkg::POWER_BITS-1:0]    r_power;
    logic                              r_sat;
    logic [cpc_pkg::POWER_BITS-1:0]    r_val;
    logic [cpc_pkg::EXP_BITS-1:0]      r_lz;
    logic [cpc_pkg::EXP_BITS-1:0]      r_exp;
    logic [cpc_pkg::MANT_BITS-1:0]     r_m;
    logic [cpc_pkg::FRAC_BITS-1:0]     r_frac;
    logic [cpc_pkg::CNT_BITS-1:0]      r_cnt;
    logic [cpc_pkg::DB_BITS-1:0]       r_db;

    logic [cpc_pkg::BCNT_BITS-1:0]     w_zb;
    logic                              w_zb_found;
    logic [cpc_pkg::BPOS_BITS-1:0]     w_lb;
    logic                              w_lb_found;
    logic [cpc_pkg::POWER_BITS-1:0]    w_byte_shift;
    logic [cpc_pkg::POWER_BITS-1:0]    w_bit_shift;
    logic [2*cpc_pkg::MANT_BITS-1:0]   w_sq;
    logic                              w_bit;
    logic [cpc_pkg::LOG_BITS-1:0]      w_l;
    logic [cpc_pkg::PROD_BITS-1:0]     w_prod;
    logic [cpc_pkg::PROD_BITS-1:0]     w_rnd;

    // leading zero bytes of the power word
    always_comb begin
        w_zb       = '0;
        w_zb_found = 1'b0;
        for (int k = cpc_pkg::NUM_BYTES - 1; k >= 0; k--) begin
            if (!w_zb_found) begin
                if (r_val[k*cpc_pkg::BYTE_BITS +: cpc_pkg::BYTE_BITS] != '0) begin
                    w_zb_found = 1'b1;
                end else begin
                    w_zb = w_zb + cpc_pkg::BCNT_BITS'(1);
                end
            end
        end
    end

    // leading zero bits inside the top byte
    always_comb begin
        w_lb       = '0;
        w_lb_found = 1'b0;
        for (int k = cpc_pkg::BYTE_BITS - 1; k >= 0; k--) begin
            if (!w_lb_found) begin
                if (r_val[cpc_pkg::POWER_BITS - cpc_pkg::BYTE_BITS + k]) begin
                    w_lb_found = 1'b1;
                end else begin
                    w_lb = w_lb + cpc_pkg::BPOS_BITS'(1);
                end
            end
        end
    end

    assign w_byte_shift = r_val << {w_zb, {cpc_pkg::BPOS_BITS{1'b0}}};
    assign w_bit_shift  = r_val << w_lb;

    assign w_sq  = (2*cpc_pkg::MANT_BITS)'(r_m) * (2*cpc_pkg::MANT_BITS)'(r_m);
    assign w_bit = w_sq[2*cpc_pkg::MANT_BITS-1];

    assign w_l    = {r_exp, r_frac};
    assign w_prod = cpc_pkg::PROD_BITS'(w_l) * cpc_pkg::PROD_BITS'(cpc_pkg::DB_SCALE);
    assign w_rnd  = w_prod + (cpc_pkg::PROD_BITS'(1) << (cpc_pkg::RND_SHIFT - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpc_pkg::LOG_IDLE: begin
                if (i_start) begin
                    n_state = cpc_pkg::LOG_NORM;
                end
            end
            cpc_pkg::LOG_NORM:  n_state = cpc_pkg::LOG_LEAD;
            cpc_pkg::LOG_LEAD:  n_state = cpc_pkg::LOG_ITER;
            cpc_pkg::LOG_ITER: begin
                if (r_cnt == cpc_pkg::CNT_BITS'(cpc_pkg::FRAC_BITS - 1)) begin
                    n_state = cpc_pkg::LOG_SCALE;
                end
            end
            cpc_pkg::LOG_SCALE: n_state = cpc_pkg::LOG_DONE;
            cpc_pkg::LOG_DONE: begin
                if (i_take) begin
                    n_state = cpc_pkg::LOG_IDLE;
                end
            end
            default:            n_state = cpc_pkg::LOG_IDLE;
        endcase
    end

    always_comb begin
        o_stat.idle = r_state == cpc_pkg::LOG_IDLE;
        o_stat.done = r_state == cpc_pkg::LOG_DONE;
        o_result.power      = r_power;
        o_result.power_db   = r_db;
        o_result.zero_power = 1'b0;
        o_result.saturated  = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpc_pkg::LOG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cpc_pkg::LOG_IDLE: begin
                if (i_start) begin
                    r_power <= i_req.power;
                    r_sat   <= i_req.sat;
                    r_val   <= i_req.power;
                end
            end
            cpc_pkg::LOG_NORM: begin
                r_val <= w_byte_shift;
                r_lz  <= {w_zb, {cpc_pkg::BPOS_BITS{1'b0}}};
            end
            cpc_pkg::LOG_LEAD: begin
                // leading one lands on the top bit of the mantissa
                r_m    <= w_bit_shift[cpc_pkg::POWER_BITS-1 -: cpc_pkg::MANT_BITS];
                r_exp  <= cpc_pkg::EXP_BITS'(cpc_pkg::POWER_BITS - 1)
                        - (r_lz + cpc_pkg::EXP_BITS'(w_lb));
                r_frac <= '0;
                r_cnt  <= '0;
            end
            cpc_pkg::LOG_ITER: begin
                // square in Q1.31; a result of two or more yields a one bit
                r_m    <= w_bit ? w_sq[2*cpc_pkg::MANT_BITS-1 -: cpc_pkg::MANT_BITS]
                                : w_sq[2*cpc_pkg::MANT_BITS-2 -: cpc_pkg::MANT_BITS];
                r_frac <= {r_frac[cpc_pkg::FRAC_BITS-2:0], w_bit};
                r_cnt  <= r_cnt + cpc_pkg::CNT_BITS'(1);
            end
            cpc_pkg::LOG_SCALE: begin
                r_db <= w_rnd[cpc_pkg::RND_SHIFT +: cpc_pkg::DB_BITS];
            end
            cpc_pkg::LOG_DONE: begin
                r_db <= r_db;
            end
            default: begin
                r_db <= r_db;
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == cpc_pkg::LOG_IDLE))
        else $error("cpc_log: start while busy");

    a_lead_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpc_pkg::LOG_LEAD)
            |-> (r_val[cpc_pkg::POWER_BITS-1 -: cpc_pkg::BYTE_BITS] != '0))
        else $error("cpc_log: top byte empty after byte normalize");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpc_pkg::LOG_ITER) |-> r_m[cpc_pkg::MANT_BITS-1])
        else $error("cpc_log: mantissa lost its leading one");

endmodule
`default_nettype wire

// File: design/cpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_back: power evaluation and result output
// Squares the channel sums, picks the power of the current mode, runs the
// dB unit when enabled and holds the result in the output register.
// ----------------------------------------------------------------------------
module cpc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_db_enable,
    input  wire logic              i_q_empty,
    input  wire cpc_pkg::t_q_entry i_q_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cpc_pkg::t_out_item     o_out_item
);

    localparam int PW = 2 * cpc_pkg::ACC_BITS;

    // stage B1: squared channel sums
    logic                              r_b1_valid;
    logic                              r_b1_mode;
    logic                              r_b1_clip;
    logic [cpc_pkg::POWER_BITS-1:0]    r_b1_pwr;
    logic [cpc_pkg::CSQ_BITS-1:0]      r_b1_sq_re;
    logic [cpc_pkg::CSQ_BITS-1:0]      r_b1_sq_im;

    // stage B2: power of the range sample
    logic                              r_b2_valid;
    logic [cpc_pkg::POWER_BITS-1:0]    r_b2_power;
    logic                              r_b2_sat;

    logic                              r_out_valid;
    cpc_pkg::t_out_item                r_out;

    logic signed [PW-1:0]              w_re_ext;
    logic signed [PW-1:0]              w_im_ext;
    logic signed [PW-1:0]              w_prod_re;
    logic signed [PW-1:0]              w_prod_im;
    logic [cpc_pkg::CSQ_BITS:0]        w_csum;
    logic                              w_csat;
    logic [cpc_pkg::POWER_BITS-1:0]    n_b2_power;
    logic                              n_b2_sat;
    logic                              w_zero;
    logic                              w_need_db;
    logic                              w_out_free;
    logic                              w_b1_go;
    logic                              w_b2_go;
    logic                              w_ld_b2;
    logic                              w_ld_log;
    logic                              w_log_start;
    cpc_pkg::t_log_req                 w_log_req;
    cpc_pkg::t_log_stat                w_log_stat;
    cpc_pkg::t_out_item                w_log_result;

    assign w_re_ext  = PW'(i_q_head.re_acc);
    assign w_im_ext  = PW'(i_q_head.im_acc);
    assign w_prod_re = w_re_ext * w_re_ext;
    assign w_prod_im = w_im_ext * w_im_ext;

    assign w_csum = (cpc_pkg::CSQ_BITS+1)'(r_b1_sq_re) + (cpc_pkg::CSQ_BITS+1)'(r_b1_sq_im);
    assign w_csat = |w_csum[cpc_pkg::CSQ_BITS:cpc_pkg::POWER_BITS];

    always_comb begin
        if (r_b1_mode == cpc_pkg::MODE_INCOHERENT) begin
            n_b2_power = r_b1_pwr;
            n_b2_sat   = r_b1_clip;
        end else begin
            n_b2_power = w_csat ? '1 : w_csum[cpc_pkg::POWER_BITS-1:0];
            n_b2_sat   = r_b1_clip | w_csat;
        end
    end

    assign w_zero     = r_b2_power == '0;
    assign w_need_db  = i_db_enable && !w_zero;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // B2 leaves only while the dB unit is idle, which keeps results in order
    assign w_b2_go     = r_b2_valid && w_log_stat.idle && (w_need_db || w_out_free);
    assign w_ld_b2     = w_b2_go && !w_need_db;
    assign w_log_start = w_b2_go && w_need_db;
    assign w_ld_log    = w_log_stat.done && w_out_free;
    assign w_b1_go     = r_b1_valid && (!r_b2_valid || w_b2_go);
    assign o_pop       = !i_q_empty && (!r_b1_valid || w_b1_go);

    assign w_log_req.power = r_b2_power;
    assign w_log_req.sat   = r_b2_sat;

    cpc_log u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_log_start),
        .i_req    (w_log_req),
        .i_take   (w_ld_log),
        .o_stat   (w_log_stat),
        .o_result (w_log_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b1_valid <= 1'b1;
            end else if (w_b1_go) begin
                r_b1_valid <= 1'b0;
            end
            if (w_b1_go) begin
                r_b2_valid <= 1'b1;
            end else if (w_b2_go) begin
                r_b2_valid <= 1'b0;
            end
            if (w_ld_log || w_ld_b2) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_mode  <= i_q_head.mode;
            r_b1_clip  <= i_q_head.clip;
            r_b1_pwr   <= i_q_head.pwr_sum;
            r_b1_sq_re <= w_prod_re[cpc_pkg::CSQ_BITS-1:0];
            r_b1_sq_im <= w_prod_im[cpc_pkg::CSQ_BITS-1:0];
        end
        if (w_b1_go) begin
            r_b2_power <= n_b2_power;
            r_b2_sat   <= n_b2_sat;
        end
        if (w_ld_log) begin
            r_out <= w_log_result;
        end else if (w_ld_b2) begin
            r_out.power      <= r_b2_power;
            r_out.power_db   <= '0;
            r_out.zero_power <= w_zero;
            r_out.saturated  <= r_b2_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ld_b2, w_ld_log}))
        else $error("cpc_back: two results loaded at once");

endmodule
`default_nettype wire
